@@ design/oldk_pkg.sv @@
// shared types and constants for the ordered list with delete by key
package oldk_pkg;

  localparam int unsigned MODE_W  = 2;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned CNT_W   = 7;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_READ   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_ENTRY  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_e;

  typedef struct packed {
    mode_e            op;
    logic [KEY_W-1:0] key;
  } cmd_t;

  typedef struct packed {
    kind_e              kind;
    status_e            status;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   position;
    logic [CNT_W-1:0]   count;
    logic               last;
  } res_t;

endpackage

@@ design/oldk_fifo.sv @@
// small synchronous first-in first-out queue of fixed-width words
module oldk_fifo #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned ADDR_W = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned ENTRIES = 2 ** ADDR_W;
  localparam int unsigned FILL_W  = ADDR_W + 1;

  logic [WIDTH-1:0]  mem_q [ENTRIES];
  logic [ADDR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FILL_W-1:0] fill_q;
  logic              wr_en, rd_en;

  assign full_o  = (fill_q == FILL_W'(ENTRIES));
  assign empty_o = (fill_q == '0);
  assign wr_en   = wr_i & ~full_o;
  assign rd_en   = rd_i & ~empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= wr_ptr_q + ADDR_W'(1);
      end
      if (rd_en) begin
        rd_ptr_q <= rd_ptr_q + ADDR_W'(1);
      end
      if (wr_en && !rd_en) begin
        fill_q <= fill_q + FILL_W'(1);
      end else if (rd_en && !wr_en) begin
        fill_q <= fill_q - FILL_W'(1);
      end
    end
  end

endmodule

@@ design/oldk_front.sv @@
// front end: accepts input transactions, decodes the mode and queues commands
module oldk_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  output logic                              full_o,
  input  logic [oldk_pkg::MODE_W-1:0]       mode_i,
  input  logic [oldk_pkg::KEY_W-1:0]        key_value_i,
  output logic                              cmd_valid_o,
  output oldk_pkg::cmd_t                    cmd_o,
  input  logic                              cmd_pop_i
);

  oldk_pkg::cmd_t              cmd_in;
  logic                        cmd_wr;
  logic                        cmd_empty;
  logic [$bits(oldk_pkg::cmd_t)-1:0] cmd_rdata;

  always_comb begin
    cmd_in.key = key_value_i;
    cmd_in.op  = oldk_pkg::MODE_APPEND;
    cmd_wr     = 1'b0;
    unique case (mode_i)
      oldk_pkg::MODE_APPEND: begin
        cmd_in.op = oldk_pkg::MODE_APPEND;
        cmd_wr    = push_i;
      end
      oldk_pkg::MODE_REMOVE: begin
        cmd_in.op = oldk_pkg::MODE_REMOVE;
        cmd_wr    = push_i;
      end
      oldk_pkg::MODE_READ: begin
        cmd_in.op = oldk_pkg::MODE_READ;
        cmd_wr    = push_i;
      end
      default: begin
        // unused mode is taken and dropped
        cmd_wr = 1'b0;
      end
    endcase
  end

  oldk_fifo #(
    .WIDTH  ($bits(oldk_pkg::cmd_t)),
    .ADDR_W (1)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cmd_wr),
    .wdata_i (cmd_in),
    .full_o  (full_o),
    .rd_i    (cmd_pop_i),
    .rdata_o (cmd_rdata),
    .empty_o (cmd_empty)
  );

  assign cmd_valid_o = ~cmd_empty;
  assign cmd_o       = oldk_pkg::cmd_t'(cmd_rdata);

endmodule

@@ design/oldk_back.sv @@
// back end: list storage, search, compaction and readout sequencing
module oldk_back #(
  parameter int unsigned DEPTH     = 32,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  oldk_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  input  logic           res_full_i,
  output logic           res_push_o,
  output oldk_pkg::res_t res_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_SHIFT  = 4'b0100,
    S_READ   = 4'b1000
  } state_e;

  state_e                state_q, state_d;
  logic [CW-1:0]         count_q, count_d;
  logic [IW-1:0]         rd_idx_q, rd_idx_d;
  logic [KEY_WIDTH-1:0]  key_q;
  logic [KEY_WIDTH-1:0]  key_in;
  logic [DEPTH-1:0]      match_q;
  logic [KEY_WIDTH-1:0]  entries_q [DEPTH];

  logic [DEPTH-1:0]      first_oh;
  logic [DEPTH-1:0]      shift_mask;
  logic [IW-1:0]         hit_idx;
  logic                  hit;
  logic                  append_we;
  logic                  shift_en;
  logic                  rd_last;

  assign key_in = KEY_WIDTH'(cmd_i.key);

  // lowest matching position
  assign first_oh   = match_q & (~match_q + DEPTH'(1));
  assign shift_mask = ~(first_oh - DEPTH'(1));
  assign hit        = |match_q;

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first_oh[i]) begin
        hit_idx = hit_idx | IW'(i);
      end
    end
  end

  assign rd_last = ((CW'(rd_idx_q) + CW'(1)) == count_q);

  always_comb begin
    state_d        = state_q;
    count_d        = count_q;
    rd_idx_d       = rd_idx_q;
    cmd_pop_o      = 1'b0;
    res_push_o     = 1'b0;
    append_we      = 1'b0;
    shift_en       = 1'b0;
    res_o.kind     = oldk_pkg::KIND_APPEND;
    res_o.status   = oldk_pkg::STAT_OK;
    res_o.value    = '0;
    res_o.position = '0;
    res_o.count    = oldk_pkg::CNT_W'(count_q);
    res_o.last     = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            oldk_pkg::MODE_APPEND: begin
              if (!res_full_i) begin
                cmd_pop_o  = 1'b1;
                res_push_o = 1'b1;
                res_o.kind = oldk_pkg::KIND_APPEND;
                if (count_q == CW'(DEPTH)) begin
                  res_o.status = oldk_pkg::STAT_FULL;
                end else begin
                  append_we   = 1'b1;
                  count_d     = count_q + CW'(1);
                  res_o.count = oldk_pkg::CNT_W'(count_d);
                end
              end
            end
            oldk_pkg::MODE_REMOVE: begin
              cmd_pop_o = 1'b1;
              state_d   = S_SEARCH;
            end
            oldk_pkg::MODE_READ: begin
              if (count_q == '0) begin
                if (!res_full_i) begin
                  cmd_pop_o    = 1'b1;
                  res_push_o   = 1'b1;
                  res_o.kind   = oldk_pkg::KIND_ENTRY;
                  res_o.status = oldk_pkg::STAT_EMPTY;
                end
              end else begin
                cmd_pop_o = 1'b1;
                rd_idx_d  = '0;
                state_d   = S_READ;
              end
            end
            default: begin
              cmd_pop_o = 1'b1;
            end
          endcase
        end
      end
      S_SEARCH: begin
        state_d = S_SHIFT;
      end
      S_SHIFT: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          res_o.kind = oldk_pkg::KIND_REMOVE;
          if (hit) begin
            shift_en       = 1'b1;
            count_d        = count_q - CW'(1);
            res_o.position = oldk_pkg::POS_W'(hit_idx);
            res_o.count    = oldk_pkg::CNT_W'(count_d);
          end else begin
            res_o.status = oldk_pkg::STAT_NOT_FOUND;
          end
          state_d = S_IDLE;
        end
      end
      S_READ: begin
        if (!res_full_i) begin
          res_push_o     = 1'b1;
          res_o.kind     = oldk_pkg::KIND_ENTRY;
          res_o.value    = oldk_pkg::VALUE_W'(entries_q[rd_idx_q]);
          res_o.position = oldk_pkg::POS_W'(rd_idx_q);
          res_o.last     = rd_last;
          if (rd_last) begin
            state_d = S_IDLE;
          end else begin
            rd_idx_d = rd_idx_q + IW'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      rd_idx_q <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rd_idx_q <= rd_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      key_q <= key_in;
    end
    if (state_q == S_SEARCH) begin
      for (int i = 0; i < DEPTH; i++) begin
        match_q[i] <= (entries_q[i] == key_q) && (CW'(i) < count_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (append_we) begin
      entries_q[count_q[IW-1:0]] <= key_in;
    end else if (shift_en) begin
      for (int j = 0; j < DEPTH - 1; j++) begin
        if (shift_mask[j]) begin
          entries_q[j] <= entries_q[j+1];
        end
      end
    end
  end

endmodule

@@ design/ordered_list_delete_by_key.sv @@
// Ordered identifier list with delete by key. Both sides behave as queues: a
// transaction enters on push while full is low and results leave on pop while
// empty is low. A two-entry command queue separates decoding from execution and
// a two-entry result queue separates execution from the consumer. In the
// execution sequencer a remove passes through a search state that registers
// the parallel key compare and a shift state that locates the first match,
// closes the gap and reports, and a readout sends one entry per cycle from
// the list registers while the result queue has room, or one empty result
// when the list is empty. Mode 3 is accepted and discarded with no result.
module ordered_list_delete_by_key #(
  parameter int unsigned DEPTH     = 32,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [oldk_pkg::MODE_W-1:0]   mode_i,
  input  logic [oldk_pkg::KEY_W-1:0]    key_value_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [1:0]                    kind_o,
  output logic [1:0]                    status_o,
  output logic [oldk_pkg::VALUE_W-1:0]  entry_value_o,
  output logic [oldk_pkg::POS_W-1:0]    position_o,
  output logic [oldk_pkg::CNT_W-1:0]    entry_count_o,
  output logic                          last_o
);

  oldk_pkg::cmd_t cmd;
  oldk_pkg::res_t res_in, res_out;
  logic           cmd_valid, cmd_pop;
  logic           res_push, res_full;
  logic [$bits(oldk_pkg::res_t)-1:0] res_rdata;

  oldk_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .mode_i      (mode_i),
    .key_value_i (key_value_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  oldk_back #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  oldk_fifo #(
    .WIDTH  ($bits(oldk_pkg::res_t)),
    .ADDR_W (1)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .rd_i    (pop),
    .rdata_o (res_rdata),
    .empty_o (empty)
  );

  assign res_out       = oldk_pkg::res_t'(res_rdata);
  assign kind_o        = res_out.kind;
  assign status_o      = res_out.status;
  assign entry_value_o = res_out.value;
  assign position_o    = res_out.position;
  assign entry_count_o = res_out.count;
  assign last_o        = res_out.last;

endmodule

@@ tb/ordered_list_delete_by_key_test.sv @@
// self-checking testbench for the ordered identifier list with delete by key
`timescale 1ns / 100ps

module ordered_list_delete_by_key_test;

  localparam int unsigned LIST_DEPTH = 32;
  localparam logic [oldk_pkg::MODE_W-1:0] MODE_IGNORED = 2'd3;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 200;

  typedef struct {
    logic [oldk_pkg::MODE_W-1:0] mode;
    logic [oldk_pkg::KEY_W-1:0] key;
    bit drain;
  } list_cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [oldk_pkg::MODE_W-1:0] mode_i = '0;
  logic [oldk_pkg::KEY_W-1:0] key_value_i = '0;
  logic empty;
  logic pop = 1'b0;
  logic [1:0] kind_o;
  logic [1:0] status_o;
  logic [oldk_pkg::VALUE_W-1:0] entry_value_o;
  logic [oldk_pkg::POS_W-1:0] position_o;
  logic [oldk_pkg::CNT_W-1:0] entry_count_o;
  logic last_o;

  list_cmd_t pending_cmds[$];
  oldk_pkg::res_t expected_rows[$];
  logic [oldk_pkg::KEY_W-1:0] plan_list[$];

  logic [oldk_pkg::KEY_W-1:0] list_mem[LIST_DEPTH];
  logic [oldk_pkg::CNT_W-1:0] list_cnt = '0;

  int fail_count = 0;
  int accepted_items = 0;
  int stall_cycles = 0;

  ordered_list_delete_by_key #(
    .DEPTH(LIST_DEPTH),
    .KEY_WIDTH(oldk_pkg::KEY_W)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push(push),
    .full(full),
    .mode_i(mode_i),
    .key_value_i(key_value_i),
    .empty(empty),
    .pop(pop),
    .kind_o(kind_o),
    .status_o(status_o),
    .entry_value_o(entry_value_o),
    .position_o(position_o),
    .entry_count_o(entry_count_o),
    .last_o(last_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic bit steady_window();
    return accepted_items >= 50 && accepted_items < 85;
  endfunction

  function automatic oldk_pkg::res_t make_row(oldk_pkg::kind_e kind, oldk_pkg::status_e status,
                                              logic [oldk_pkg::VALUE_W-1:0] value,
                                              int unsigned pos,
                                              logic [oldk_pkg::CNT_W-1:0] cnt, logic last);
    oldk_pkg::res_t r;
    r.kind = kind;
    r.status = status;
    r.value = value;
    r.position = pos[oldk_pkg::POS_W-1:0];
    r.count = cnt;
    r.last = last;
    return r;
  endfunction

  // expected rows of one accepted transaction, list state updated in place
  task automatic predict_list_op(input logic [oldk_pkg::MODE_W-1:0] op,
                                 input logic [oldk_pkg::KEY_W-1:0] key);
    int hit;
    hit = -1;
    case (op)
      oldk_pkg::MODE_APPEND: begin
        if (list_cnt >= LIST_DEPTH) begin
          expected_rows.push_back(make_row(oldk_pkg::KIND_APPEND, oldk_pkg::STAT_FULL, '0, 0,
                                           list_cnt, 1'b1));
        end else begin
          list_mem[list_cnt] = key;
          list_cnt++;
          expected_rows.push_back(make_row(oldk_pkg::KIND_APPEND, oldk_pkg::STAT_OK, '0, 0,
                                           list_cnt, 1'b1));
        end
      end
      oldk_pkg::MODE_REMOVE: begin
        for (int i = 0; i < list_cnt; i++) begin
          if (hit < 0 && list_mem[i] == key) hit = i;
        end
        if (hit < 0) begin
          expected_rows.push_back(make_row(oldk_pkg::KIND_REMOVE, oldk_pkg::STAT_NOT_FOUND, '0,
                                           0, list_cnt, 1'b1));
        end else begin
          for (int j = hit; j + 1 < list_cnt; j++) list_mem[j] = list_mem[j + 1];
          list_cnt--;
          expected_rows.push_back(make_row(oldk_pkg::KIND_REMOVE, oldk_pkg::STAT_OK, '0, hit,
                                           list_cnt, 1'b1));
        end
      end
      oldk_pkg::MODE_READ: begin
        if (list_cnt == 0) begin
          expected_rows.push_back(make_row(oldk_pkg::KIND_ENTRY, oldk_pkg::STAT_EMPTY, '0, 0,
                                           '0, 1'b1));
        end else begin
          for (int i = 0; i < list_cnt; i++) begin
            expected_rows.push_back(make_row(oldk_pkg::KIND_ENTRY, oldk_pkg::STAT_OK,
                                             list_mem[i], i, list_cnt, (i + 1 == list_cnt)));
          end
        end
      end
      default: ;
    endcase
  endtask

  // planning copy of the list steers remove keys toward stored entries
  task automatic add_cmd(input logic [oldk_pkg::MODE_W-1:0] op,
                         input logic [oldk_pkg::KEY_W-1:0] key, input bit drain = 1'b0);
    list_cmd_t c;
    int hit;
    c.mode = op;
    c.key = key;
    c.drain = drain;
    pending_cmds.push_back(c);
    hit = -1;
    if (op == oldk_pkg::MODE_APPEND && plan_list.size() < LIST_DEPTH) plan_list.push_back(key);
    if (op == oldk_pkg::MODE_REMOVE) begin
      foreach (plan_list[i]) if (hit < 0 && plan_list[i] == key) hit = i;
      if (hit >= 0) plan_list.delete(hit);
    end
  endtask

  function automatic logic [oldk_pkg::KEY_W-1:0] fresh_key();
    if ($urandom_range(3) == 0) return oldk_pkg::KEY_W'($urandom_range(7));
    return $urandom();
  endfunction

  function automatic logic [oldk_pkg::KEY_W-1:0] remove_key();
    if (plan_list.size() > 0 && $urandom_range(99) < 80)
      return plan_list[$urandom_range(plan_list.size() - 1)];
    return fresh_key();
  endfunction

  task automatic add_random_cmd(input bit drain);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 42) add_cmd(oldk_pkg::MODE_APPEND, fresh_key(), drain);
    else if (roll < 78) add_cmd(oldk_pkg::MODE_REMOVE, remove_key(), drain);
    else if (roll < 94) add_cmd(oldk_pkg::MODE_READ, $urandom(), drain);
    else add_cmd(MODE_IGNORED, $urandom(), drain);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    bit take;
    logic next_push;
    if (!rst_ni) begin
      push <= 1'b0;
      mode_i <= '0;
      key_value_i <= '0;
    end else begin
      take = push && !full;
      if (take) begin
        predict_list_op(mode_i, key_value_i);
        void'(pending_cmds.pop_front());
        accepted_items++;
      end
      if (push && !take) begin
        next_push = 1'b1;
      end else if (pending_cmds.size() > 0 && (steady_window() || $urandom_range(99) >= 14)
                   && !(pending_cmds[0].drain && expected_rows.size() != 0)) begin
        next_push = 1'b1;
        mode_i <= pending_cmds[0].mode;
        key_value_i <= pending_cmds[0].key;
      end else begin
        next_push = 1'b0;
      end
      push <= next_push;
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    oldk_pkg::res_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_rows.size() == 0) begin
          $error("unexpected result transaction: kind %0d status %0d value %0h",
                 kind_o, status_o, entry_value_o);
          fail_count++;
        end else begin
          want = expected_rows.pop_front();
          if (kind_o !== want.kind) begin
            $error("kind expected %0d actual %0d", want.kind, kind_o);
            fail_count++;
          end
          if (status_o !== want.status) begin
            $error("status expected %0d actual %0d", want.status, status_o);
            fail_count++;
          end
          if (entry_value_o !== want.value) begin
            $error("entry_value expected %0h actual %0h", want.value, entry_value_o);
            fail_count++;
          end
          if (position_o !== want.position) begin
            $error("position expected %0d actual %0d", want.position, position_o);
            fail_count++;
          end
          if (entry_count_o !== want.count) begin
            $error("entry_count expected %0d actual %0d", want.count, entry_count_o);
            fail_count++;
          end
          if (last_o !== want.last) begin
            $error("last expected %0d actual %0d", want.last, last_o);
            fail_count++;
          end
        end
      end
      pop <= steady_window() || $urandom_range(99) >= 14;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("ordered_list_delete_by_key_test NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int mixed_items;
    mixed_items = 12;

    // directed: empty list, extremes, duplicates, absent key, unused mode
    add_cmd(oldk_pkg::MODE_READ, 32'hFFFF_FFFF);
    add_cmd(oldk_pkg::MODE_REMOVE, 32'h0000_0000);
    add_cmd(oldk_pkg::MODE_APPEND, 32'h0000_0000);
    add_cmd(oldk_pkg::MODE_APPEND, 32'hFFFF_FFFF);
    add_cmd(oldk_pkg::MODE_APPEND, 32'h0000_0005);
    add_cmd(oldk_pkg::MODE_APPEND, 32'h0000_0005);
    add_cmd(oldk_pkg::MODE_APPEND, 32'h8000_0000);
    add_cmd(oldk_pkg::MODE_READ, 32'h0000_0000);
    add_cmd(oldk_pkg::MODE_REMOVE, 32'h0000_0005);
    add_cmd(oldk_pkg::MODE_READ, 32'h0000_0000);
    add_cmd(oldk_pkg::MODE_REMOVE, 32'h1234_5678);
    add_cmd(MODE_IGNORED, 32'hFFFF_FFFF);
    add_cmd(oldk_pkg::MODE_READ, 32'h5555_5555);
    add_cmd(oldk_pkg::MODE_REMOVE, 32'hFFFF_FFFF);
    add_cmd(oldk_pkg::MODE_REMOVE, 32'h0000_0000);
    add_cmd(oldk_pkg::MODE_REMOVE, 32'h0000_0005);
    add_cmd(oldk_pkg::MODE_REMOVE, 32'h8000_0000);
    add_cmd(oldk_pkg::MODE_READ, 32'hAAAA_AAAA);
    add_cmd(MODE_IGNORED, 32'h0000_0000);

    // fill to capacity, overflow, then read back
    while (plan_list.size() < LIST_DEPTH) add_cmd(oldk_pkg::MODE_APPEND, fresh_key());
    repeat (3) add_cmd(oldk_pkg::MODE_APPEND, fresh_key());
    add_cmd(oldk_pkg::MODE_READ, $urandom());
    repeat (4) add_cmd(oldk_pkg::MODE_REMOVE, remove_key());
    add_cmd(oldk_pkg::MODE_READ, $urandom(), 1'b1);

    for (int n = 0; n < mixed_items; n++) add_random_cmd(n == mixed_items / 2);

    // empty the list through removes and confirm
    while (plan_list.size() > 0) add_cmd(oldk_pkg::MODE_REMOVE, remove_key());
    add_cmd(oldk_pkg::MODE_REMOVE, fresh_key());
    add_cmd(oldk_pkg::MODE_READ, $urandom());

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i); while (pending_cmds.size() != 0 || expected_rows.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && expected_rows.size() == 0) begin
      $display("ordered_list_delete_by_key_test OK");
    end else begin
      $display("ordered_list_delete_by_key_test NOT OK");
    end
    $finish;
  end

endmodule
